@@ src/mafs_pkg.sv @@
// ----------------------------------------------------------------------------
// mafs_pkg
// shared types, codes and constants of the mpeg audio frame sync scanner
// ----------------------------------------------------------------------------
`default_nettype none

package mafs_pkg;

    localparam int OFFSET_BITS = 32;

    localparam logic [31:0] COUNT_LIMIT = (OFFSET_BITS >= 32) ? 32'hFFFF_FFFF
        : 32'((64'd1 << OFFSET_BITS) - 64'd1);

    // parse phases
    localparam logic [2:0] PH_HEAD4   = 3'd0;
    localparam logic [2:0] PH_ID3REST = 3'd1;
    localparam logic [2:0] PH_AIDLEN  = 3'd2;
    localparam logic [2:0] PH_SKIPID3 = 3'd3;
    localparam logic [2:0] PH_SKIPAID = 3'd4;
    localparam logic [2:0] PH_SYNC    = 3'd5;
    localparam logic [2:0] PH_DONE    = 3'd6;

    localparam logic [23:0] ID3_TAG = 24'h494433;
    localparam logic [31:0] AID_TAG = 32'h4169_4401;

    localparam logic [3:0] ID3_HEAD_LEN = 4'd10;
    localparam logic [3:0] ID3_LEN_FIRST = 4'd7;
    localparam logic [3:0] HEAD4_LEN = 4'd4;
    localparam logic [3:0] AID_LEN_BYTES = 4'd2;
    localparam logic [15:0] AID_HEAD_LEN = 16'd6;

    // header field codes
    localparam logic [1:0] VER_RESERVED = 2'b01;
    localparam logic [1:0] VER_MPEG1    = 2'b11;
    localparam logic [1:0] LAYER_III_CODE = 2'b01;
    localparam logic [1:0] LAYER_II_CODE  = 2'b10;
    localparam logic [1:0] LAYER_I_CODE   = 2'b11;
    localparam logic [3:0] BITRATE_BAD  = 4'hF;
    localparam logic [3:0] BITRATE_FREE = 4'h0;
    localparam logic [1:0] RATE_RESERVED = 2'b11;
    localparam logic [1:0] EMPH_RESERVED = 2'b10;

    localparam logic [1:0] LAYER_SELECT_RESET = 2'd3;

    // disallowed channel modes of mpeg-1 layer ii, one bit per mode
    localparam logic [3:0] L2_BAD_MODES [16] = '{
        4'd0, 4'd7, 4'd7, 4'd7, 4'd0, 4'd7, 4'd0, 4'd0,
        4'd0, 4'd0, 4'd0, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       stream_start;
    } item_t;

    typedef struct packed {
        logic [31:0] header_word;
        logic        free_format;
        logic [31:0] header_offset;
        logic [31:0] skipped_bytes;
    } result_t;

    typedef struct packed {
        logic    hit;
        result_t data;
    } scan_t;

endpackage

`default_nettype wire

@@ src/mafs_hdr_check.sv @@
// ----------------------------------------------------------------------------
// mafs_hdr_check
// validity check of a four byte mpeg audio header window
// ----------------------------------------------------------------------------
`default_nettype none

module mafs_hdr_check (
    input  wire logic [31:0] window,
    input  wire logic [1:0]  layer_select,
    output logic             ok
);
    import mafs_pkg::*;

    logic [1:0] version;
    logic [1:0] layer;
    logic [3:0] bitrate;
    logic [1:0] rate;
    logic [1:0] mode;
    logic [1:0] emph;
    logic       layer_ok;
    logic       l2_bad;

    assign version = window[20:19];
    assign layer   = window[18:17];
    assign bitrate = window[15:12];
    assign rate    = window[11:10];
    assign mode    = window[7:6];
    assign emph    = window[1:0];

    always_comb
    begin
        case (layer)
            LAYER_III_CODE: layer_ok = (layer_select == 2'd3);
            LAYER_II_CODE:  layer_ok = (layer_select == 2'd2);
            LAYER_I_CODE:   layer_ok = (layer_select == 2'd1);
            default:        layer_ok = 1'b0;
        endcase
    end

    assign l2_bad = (version == VER_MPEG1) && (layer == LAYER_II_CODE)
                    && L2_BAD_MODES[bitrate][mode];

    assign ok = (window[31:21] == 11'h7FF) && (version != VER_RESERVED) && layer_ok
                && (bitrate != BITRATE_BAD) && (rate != RATE_RESERVED)
                && (emph != EMPH_RESERVED) && !l2_bad;

endmodule

`default_nettype wire

@@ src/mafs_parser.sv @@
// ----------------------------------------------------------------------------
// mafs_parser
// tag skipping and sync search state, one byte per step
// ----------------------------------------------------------------------------
`default_nettype none

module mafs_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire mafs_pkg::item_t item,
    input  wire logic [1:0]      layer_select,
    output mafs_pkg::scan_t      scan
);
    import mafs_pkg::*;

    logic [2:0]  phase_reg, phase_next, phase_c;
    logic [31:0] window_reg, window_next;
    logic [3:0]  fill_reg, fill_next, fill_c;
    logic [27:0] skip_reg, skip_next, skip_c;
    logic [31:0] pos_reg, pos_next, pos_c;
    logic [31:0] skipped_reg, skipped_next, skipped_c;

    logic [28:0] add_amt;
    logic        add_en;
    logic [32:0] add_sum;
    logic        check;
    logic        hdr_ok;
    logic [15:0] aid_len;
    logic [31:0] offset;

    assign window_next = {(item.stream_start ? 24'd0 : window_reg[23:0]), item.data_byte};
    assign aid_len = {item.data_byte, window_next[15:8]};

    mafs_hdr_check u_hdr_check (
        .window       (window_next),
        .layer_select (layer_select),
        .ok           (hdr_ok)
    );

    always_comb
    begin
        phase_c   = item.stream_start ? PH_HEAD4 : phase_reg;
        fill_c    = item.stream_start ? 4'd0 : fill_reg;
        skip_c    = item.stream_start ? 28'd0 : skip_reg;
        pos_c     = item.stream_start ? 32'd0 : pos_reg;
        skipped_c = item.stream_start ? 32'd0 : skipped_reg;

        phase_next   = phase_c;
        fill_next    = fill_c;
        skip_next    = skip_c;
        pos_next     = pos_c;
        skipped_next = skipped_c;
        add_amt      = 29'd0;
        add_en       = 1'b0;
        check        = 1'b0;
        add_sum      = 33'd0;

        if (phase_c != PH_DONE)
        begin
            pos_next = (pos_c >= COUNT_LIMIT) ? COUNT_LIMIT : pos_c + 32'd1;
            case (phase_c)
                PH_HEAD4:
                begin
                    fill_next = fill_c + 4'd1;
                    if (fill_next >= HEAD4_LEN)
                    begin
                        if (window_next[31:8] == ID3_TAG)
                        begin
                            phase_next = PH_ID3REST;
                        end
                        else if (window_next == AID_TAG)
                        begin
                            phase_next = PH_AIDLEN;
                            fill_next  = 4'd0;
                        end
                        else
                        begin
                            phase_next = PH_SYNC;
                            check      = 1'b1;
                        end
                    end
                end
                PH_ID3REST:
                begin
                    fill_next = fill_c + 4'd1;
                    // syncsafe length, seven bits per byte
                    if (fill_next >= ID3_LEN_FIRST)
                    begin
                        skip_next = {skip_c[20:0], item.data_byte[6:0]};
                    end
                    if (fill_next >= ID3_HEAD_LEN)
                    begin
                        add_amt    = 29'(skip_next) + 29'(ID3_HEAD_LEN);
                        add_en     = 1'b1;
                        fill_next  = 4'd0;
                        phase_next = (skip_next != 28'd0) ? PH_SKIPID3 : PH_HEAD4;
                    end
                end
                PH_AIDLEN:
                begin
                    fill_next = fill_c + 4'd1;
                    if (fill_next >= AID_LEN_BYTES)
                    begin
                        skip_next  = (aid_len > AID_HEAD_LEN)
                                   ? 28'(aid_len - AID_HEAD_LEN) : 28'd0;
                        add_amt    = (aid_len > AID_HEAD_LEN)
                                   ? 29'(aid_len) : 29'(AID_HEAD_LEN);
                        add_en     = 1'b1;
                        fill_next  = 4'd0;
                        phase_next = (skip_next != 28'd0) ? PH_SKIPAID : PH_SYNC;
                    end
                end
                PH_SKIPID3, PH_SKIPAID:
                begin
                    if (skip_c != 28'd0)
                    begin
                        skip_next = skip_c - 28'd1;
                    end
                    if (skip_next == 28'd0)
                    begin
                        fill_next  = 4'd0;
                        phase_next = (phase_c == PH_SKIPID3) ? PH_HEAD4 : PH_SYNC;
                    end
                end
                PH_SYNC:
                begin
                    if (fill_c < HEAD4_LEN)
                    begin
                        fill_next = fill_c + 4'd1;
                    end
                    check = (fill_next >= HEAD4_LEN);
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase

            if (add_en)
            begin
                add_sum = {1'b0, skipped_c} + 33'(add_amt);
                skipped_next = (add_sum > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT
                                                               : add_sum[31:0];
            end

            if (check && hdr_ok)
            begin
                phase_next = PH_DONE;
            end
        end
    end

    assign offset = (pos_next >= COUNT_LIMIT) ? COUNT_LIMIT : pos_next - 32'd4;

    assign scan.hit                = step && check && hdr_ok;
    assign scan.data.header_word   = window_next;
    assign scan.data.free_format   = (window_next[15:12] == BITRATE_FREE);
    assign scan.data.header_offset = offset;
    assign scan.data.skipped_bytes = skipped_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEAD4;
            window_reg  <= 32'd0;
            fill_reg    <= 4'd0;
            skip_reg    <= 28'd0;
            pos_reg     <= 32'd0;
            skipped_reg <= 32'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            window_reg  <= (phase_c != PH_DONE) ? window_next : 32'd0;
            fill_reg    <= fill_next;
            skip_reg    <= skip_next;
            pos_reg     <= pos_next;
            skipped_reg <= skipped_next;
        end
    end

    // skip phases always have bytes left
    a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SKIPID3 || phase_reg == PH_SKIPAID) |-> (skip_reg != 28'd0))
        else $error("skip phase with zero count");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= ID3_HEAD_LEN)
        else $error("fill count out of range");

    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE && !item.stream_start) |-> !scan.hit)
        else $error("result after header found");

    a_pos_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !item.stream_start) |=> (pos_reg >= $past(pos_reg)))
        else $error("stream position went backward");

    a_hit_done: assert property (@(posedge clk) disable iff (!rst_n)
        scan.hit |=> (phase_reg == PH_DONE))
        else $error("header found but scan not finished");

endmodule

`default_nettype wire

@@ src/mpeg_audio_frame_sync_scanner.sv @@
// ----------------------------------------------------------------------------
// mpeg_audio_frame_sync_scanner
// skips id3v2 tags and an aid header, then finds the first valid mpeg audio
// frame header of the selected layer
// ----------------------------------------------------------------------------
// The scanner takes one byte per clock, sustained, with no gaps between
// stream bytes while no result is stalled: a request is held in an input
// register until it is parsed by a single pass of logic, and the header result
// lands in an output register when the byte that completes the header is parsed.
// While a result waits, the input register can still accept one byte;
// a stalled result stops byte intake only when another byte is waiting to be
// processed. Set stream_start on the first byte of each file; after a header
// is reported all further bytes are dropped until the next stream start.
// Change layer_select only while the scanner is idle.
`default_nettype none

module mpeg_audio_frame_sync_scanner (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire mafs_pkg::item_t   item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output mafs_pkg::result_t      result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        layer_select
);
    import mafs_pkg::*;

    item_t      item_reg;
    logic       item_valid_reg;
    result_t    result_reg;
    logic       result_valid_reg;
    logic [1:0] layer_reg;
    logic       step;
    scan_t      scan;

    assign step       = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || step;
    assign cfg_ready  = 1'b1;

    mafs_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (item_reg),
        .layer_select (layer_reg),
        .scan         (scan)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_reg <= LAYER_SELECT_RESET;
        end
        else if (cfg_valid)
        begin
            layer_reg <= layer_select;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (scan.hit)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan.hit)
        begin
            result_reg <= scan.data;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // a waiting byte is only held while the result register is blocked
    a_hold_reason: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !step) |-> (result_valid_reg && !result_ready))
        else $error("input stage stalled without cause");

    // a result is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_ready) |-> !scan.hit)
        else $error("pending result overwritten");

    a_step_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        scan.hit |-> item_valid_reg)
        else $error("result without a byte");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the mpeg audio frame sync scanner
// ----------------------------------------------------------------------------
// Streams of bytes go in one request at a time. Most of them are well-formed:
// chains of id3v2 tags, an optional aid header, some junk, and then frame
// headers of the selected layer. The rest are noise, cut-off streams, and tags
// with huge lengths that a new stream start interrupts. A scoreboard predicts
// the header that each stream yields and compares every result field with the
// oldest prediction. Both handshake sides idle at random. The layer select is
// rewritten between phases, only while the scanner has nothing left to do.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mafs_pkg::*;

    localparam int RUN_LIMIT     = 400000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_ITEMS   = 80;
    localparam int PHASE_HEADERS = 2;
    localparam int SHOWN_ERRORS  = 10;

    localparam logic [1:0] LAYER_I   = 2'd1;
    localparam logic [1:0] LAYER_II  = 2'd2;
    localparam logic [1:0] LAYER_III = 2'd3;

    // {stream start, byte}
    localparam logic [8:0] DIRECTED_BYTES [31] = '{
        9'h0FF, 9'h0FB, 9'h000, 9'h000, 9'h000,
        9'h149, 9'h044, 9'h033, 9'h004, 9'h000,
        9'h000, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
        9'h141, 9'h069, 9'h044, 9'h001, 9'h0FF, 9'h0FF,
        9'h141, 9'h069, 9'h044, 9'h001, 9'h005,
        9'h000, 9'h0FF, 9'h0FB, 9'h0E4, 9'h0FF
    };

    class frame_sync_scoreboard;
        logic [1:0]  layer;
        logic [2:0]  phase;
        logic [31:0] window;
        logic [3:0]  fill;
        logic [27:0] skip_left;
        logic [31:0] position;
        logic [31:0] skipped;
        logic [27:0] id3_len;
        result_t     expected_headers [$];
        int          mismatches;
        int          headers_found;

        function new();
            layer = LAYER_SELECT_RESET;
            mismatches = 0;
            headers_found = 0;
            restart();
        endfunction

        function void restart();
            phase = PH_HEAD4;
            window = '0;
            fill = '0;
            skip_left = '0;
            position = '0;
            skipped = '0;
            id3_len = '0;
        endfunction

        function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
            logic [32:0] sum;
            sum = {1'b0, a} + {1'b0, b};
            return (sum > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT : sum[31:0];
        endfunction

        function bit header_ok(logic [31:0] w, logic [1:0] lay);
            logic [1:0] ver;
            logic [1:0] code;
            ver = w[20:19];
            code = w[18:17];
            if (w[31:21] != 11'h7FF || ver == VER_RESERVED)
                return 1'b0;
            case (code)
                LAYER_III_CODE: if (lay != LAYER_III) return 1'b0;
                LAYER_II_CODE:  if (lay != LAYER_II) return 1'b0;
                LAYER_I_CODE:   if (lay != LAYER_I) return 1'b0;
                default:        return 1'b0;
            endcase
            if (w[15:12] == BITRATE_BAD || w[11:10] == RATE_RESERVED)
                return 1'b0;
            if (ver == VER_MPEG1 && code == LAYER_II_CODE && L2_BAD_MODES[w[15:12]][w[7:6]])
                return 1'b0;
            return w[1:0] != EMPH_RESERVED;
        endfunction

        function void take_byte(item_t it);
            logic        check;
            logic [15:0] aid_len;
            result_t     r;
            check = 1'b0;
            if (it.stream_start)
                restart();
            if (phase == PH_DONE)
                return;
            position = sat_add(position, 32'd1);
            window = {window[23:0], it.data_byte};
            case (phase)
                PH_HEAD4:
                begin
                    fill++;
                    if (fill >= HEAD4_LEN)
                    begin
                        if (window[31:8] == ID3_TAG)
                        begin
                            phase = PH_ID3REST;
                            id3_len = '0;
                        end
                        else if (window == AID_TAG)
                        begin
                            phase = PH_AIDLEN;
                            fill = '0;
                        end
                        else
                        begin
                            phase = PH_SYNC;
                            check = 1'b1;
                        end
                    end
                end
                PH_ID3REST:
                begin
                    fill++;
                    if (fill >= ID3_LEN_FIRST)
                        id3_len = {id3_len[20:0], it.data_byte[6:0]};
                    if (fill >= ID3_HEAD_LEN)
                    begin
                        skipped = sat_add(skipped, 32'd10 + 32'(id3_len));
                        skip_left = id3_len;
                        fill = '0;
                        phase = (skip_left != 0) ? PH_SKIPID3 : PH_HEAD4;
                    end
                end
                PH_AIDLEN:
                begin
                    fill++;
                    if (fill >= AID_LEN_BYTES)
                    begin
                        aid_len = {it.data_byte, window[15:8]};
                        skip_left = (aid_len > AID_HEAD_LEN) ? 28'(aid_len - AID_HEAD_LEN) : '0;
                        skipped = sat_add(skipped, 32'd6 + 32'(skip_left));
                        fill = '0;
                        phase = (skip_left != 0) ? PH_SKIPAID : PH_SYNC;
                    end
                end
                PH_SKIPID3, PH_SKIPAID:
                begin
                    if (skip_left > 0)
                        skip_left--;
                    if (skip_left == 0)
                    begin
                        fill = '0;
                        phase = (phase == PH_SKIPID3) ? PH_HEAD4 : PH_SYNC;
                    end
                end
                PH_SYNC:
                begin
                    if (fill < HEAD4_LEN)
                        fill++;
                    check = (fill >= HEAD4_LEN);
                end
                default:
                    phase = PH_DONE;
            endcase
            if (check && header_ok(window, layer))
            begin
                phase = PH_DONE;
                r.header_word = window;
                r.free_format = (window[15:12] == BITRATE_FREE);
                r.header_offset = (position >= COUNT_LIMIT) ? COUNT_LIMIT : position - 32'd4;
                r.skipped_bytes = skipped;
                expected_headers.push_back(r);
                headers_found++;
            end
        endfunction

        function void check_header(result_t got);
            result_t want;
            if (expected_headers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("unexpected header %h at offset %0d",
                             got.header_word, got.header_offset);
                return;
            end
            want = expected_headers.pop_front();
            if (got.header_word !== want.header_word || got.free_format !== want.free_format
                || got.header_offset !== want.header_offset
                || got.skipped_bytes !== want.skipped_bytes)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("header mismatch: expected %h %b %0d %0d, got %h %b %0d %0d",
                             want.header_word, want.free_format, want.header_offset,
                             want.skipped_bytes, got.header_word, got.free_format,
                             got.header_offset, got.skipped_bytes);
            end
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    item_t      item = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    result_t    result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] layer_select = LAYER_SELECT_RESET;

    frame_sync_scoreboard sb;
    item_t      stream_q [$];
    logic [1:0] cur_layer = LAYER_SELECT_RESET;
    bit         quiet = 1'b0;
    bit         force_restart = 1'b0;
    int         sink_hold = 0;
    int         cycle_count = 0;

    mpeg_audio_frame_sync_scanner u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .layer_select (layer_select)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.layer = layer_select;
            if (item_valid && item_ready)
                sb.take_byte(item);
            if (result_valid && result_ready)
                sb.check_header(result);
        end
    end

    function automatic int draw_gap();
        return quiet ? 0 : int'($urandom_range(0, 14));
    endfunction

    // result side draws a random stall, possibly none, after each accepted header
    always @(posedge clk)
    begin
        if (result_valid === 1'b1 && result_ready)
            sink_hold = draw_gap();
        else if (sink_hold > 0)
            sink_hold = sink_hold - 1;
        result_ready <= (sink_hold == 0);
    end

    function automatic void add_byte(logic [7:0] b, logic s);
        stream_q.push_back(item_t'{data_byte: b, stream_start: s});
    endfunction

    function automatic void add_id3(logic [27:0] len);
        add_byte(8'h49, 1'b0);
        add_byte(8'h44, 1'b0);
        add_byte(8'h33, 1'b0);
        repeat (3) add_byte(8'($urandom()), 1'b0);
        for (int i = 3; i >= 0; i--)
            add_byte({1'($urandom_range(0, 1)), len[i*7 +: 7]}, 1'b0);
    endfunction

    function automatic void add_aid(logic [15:0] len);
        add_byte(8'h41, 1'b0);
        add_byte(8'h69, 1'b0);
        add_byte(8'h44, 1'b0);
        add_byte(8'h01, 1'b0);
        add_byte(len[7:0], 1'b0);
        add_byte(len[15:8], 1'b0);
    endfunction

    function automatic void add_header(logic [1:0] lay, bit valid);
        logic [31:0] w;
        logic [1:0]  code;
        case (lay)
            LAYER_I:  code = LAYER_I_CODE;
            LAYER_II: code = LAYER_II_CODE;
            default:  code = LAYER_III_CODE;
        endcase
        if (valid)
        begin
            do
            begin
                w = {11'h7FF, 21'($urandom())};
                w[18:17] = code;
            end
            while (!sb.header_ok(w, lay));
        end
        else
        begin
            w = {11'h7FF, 21'($urandom())};
            if ($urandom_range(0, 1))
                w[18:17] = code;
            if (lay == LAYER_II && $urandom_range(0, 1))
                w[20:17] = {VER_MPEG1, LAYER_II_CODE};
            if ($urandom_range(0, 3) == 0)
                w[31:24] = 8'($urandom());
        end
        for (int i = 3; i >= 0; i--)
            add_byte(w[i*8 +: 8], 1'b0);
    endfunction

    // returns the stream length without its trailing junk, or zero when it has no stream start
    function automatic int build_stream();
        bit start;
        int counted;
        start = force_restart || ($urandom_range(0, 9) != 0);
        force_restart = 1'b0;
        stream_q.delete();
        case ($urandom_range(0, 19))
            0, 1:
                repeat ($urandom_range(1, 12))
                    add_byte(8'($urandom()), $urandom_range(0, 7) == 0);
            2:
            begin
                add_id3($urandom_range(0, 1) ? 28'hFFF_FFFF : 28'($urandom()));
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom()), 1'b0);
                force_restart = 1'b1;
            end
            3:
            begin
                add_aid(16'($urandom_range(256, 65535)));
                repeat ($urandom_range(0, 3)) add_byte(8'($urandom()), 1'b0);
                force_restart = 1'b1;
            end
            default:
            begin
                repeat (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0)
                    add_id3(28'($urandom_range(0, 12)));
                if ($urandom_range(0, 2) == 0)
                    add_aid(16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                             : $urandom_range(0, 12)));
                repeat ($urandom_range(0, 5))
                    add_byte(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom()), 1'b0);
                if ($urandom_range(0, 1))
                    add_header(cur_layer, 1'b0);
                add_header(cur_layer, 1'b1);
                if ($urandom_range(0, 5) == 0)
                    repeat (stream_q.size() - $urandom_range(1, stream_q.size() - 1))
                        void'(stream_q.pop_back());
            end
        endcase
        if (start)
            stream_q[0].stream_start = 1'b1;
        counted = start ? stream_q.size() : 0;
        repeat ($urandom_range(0, 2)) add_byte(8'($urandom()), 1'b0);
        return counted;
    endfunction

    task automatic send_item(input item_t it);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
    endtask

    task automatic send_stream();
        foreach (stream_q[i])
            send_item(stream_q[i]);
        stream_q.delete();
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (sb.expected_headers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_layer(input logic [1:0] lay);
        cfg_valid <= 1'b1;
        layer_select <= lay;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_layer = lay;
    endtask

    initial
    begin
        logic [1:0] phase_layers [5];
        int         phase_bytes;
        int         header_goal;
        sb = new();
        phase_layers[0] = LAYER_I;
        phase_layers[1] = LAYER_II;
        phase_layers[2] = LAYER_III;
        phase_layers[3] = LAYER_II;
        phase_layers[4] = 2'($urandom_range(1, 3));
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset acts as stream start, huge tag lengths, short aid header
        foreach (DIRECTED_BYTES[i])
            add_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
        send_stream();

        foreach (phase_layers[p])
        begin
            drain();
            write_layer(phase_layers[p]);
            phase_bytes = 0;
            header_goal = sb.headers_found + PHASE_HEADERS;
            force_restart = 1'b1;
            while (phase_bytes < PHASE_ITEMS || sb.headers_found < header_goal)
            begin
                quiet = ($urandom_range(0, 3) == 0);
                phase_bytes += build_stream();
                send_stream();
                if ($urandom_range(0, 9) == 0)
                    drain();
            end
        end

        quiet = 1'b0;
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_headers.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
